// ===== rtl/core/brcd_pkg.sv =====
package brcd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PROTOCOL_MODE = 3'd0;
    localparam logic [2:0] CFG_FAN_COUNT     = 3'd1;
    localparam logic [2:0] CFG_GPIO_COUNT    = 3'd2;
    localparam logic [2:0] CFG_DEVICE_NAME   = 3'd3;
    localparam logic [2:0] CFG_RO_OFFSET     = 3'd4;
    localparam logic [2:0] CFG_RO_POLICY     = 3'd5;

    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] MODE_RAW = 2'd2;

    // register map
    localparam logic [7:0] MARKER         = 8'hFF;
    localparam logic [7:0] FIRST_SYNTH    = 8'd241;
    localparam logic [7:0] REG_CRC_HI     = 8'd241;
    localparam logic [7:0] REG_CRC_LO     = 8'd242;
    localparam logic [7:0] REG_GPIO_COUNT = 8'd243;
    localparam logic [7:0] REG_FAN_COUNT  = 8'd244;
    localparam logic [7:0] REG_RO_OFFSET  = 8'd245;
    localparam logic [7:0] REG_RO_POLICY  = 8'd246;
    localparam logic [7:0] REG_NAME_FIRST = 8'd247;
    localparam logic [7:0] REG_ZERO       = 8'd255;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // one access to the register store per cycle
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } t_store_req;

endpackage

// ===== rtl/core/brcd_store.sv =====
module brcd_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  brcd_pkg::t_store_req   i_req,
    output logic [7:0]             o_rd_data
);
    import brcd_pkg::*;

    logic [7:0]   r_mem [256];
    logic [255:0] r_valid;
    logic [7:0]   r_rd_data;
    logic         r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.raddr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 8'd0;

endmodule

// ===== rtl/core/byte_register_command_decoder_unit.sv =====
// A byte's result word is registered twice: first in stage 1, which holds the store read,
// and then in the output register, which drives o_out_valid.
// Throughput: one byte per cycle while o_in_stall is low; the store takes one read or one write per cycle.
// Bytes that only frame a command (index, marker, dropped write) give no result word.
// Reset (i_rst_n low, synchronous): configuration to defaults, framing to idle,
// raw position to 0, store valid bits cleared so every entry reads zero.
module byte_register_command_decoder_unit #(
    parameter int NAME_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [brcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // received bytes
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_rx_byte,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_kind,
    output logic [7:0]                        o_reg_index,
    output logic [7:0]                        o_reg_value
);
    import brcd_pkg::*;

    localparam int NAME_W = NAME_BYTES * 8;

    // framing phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;

    // one CRC-16/0x1021 byte update, table-free form
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return (crc << 8) ^ (16'(x) << 12) ^ (16'(x) << 5) ^ 16'(x);
    endfunction

    // configuration registers
    logic [1:0]        r_protocol_mode;
    logic [4:0]        r_fan_count;
    logic [4:0]        r_gpio_count;
    logic [NAME_W-1:0] r_device_name;
    logic [7:0]        r_ro_offset;
    logic              r_ro_policy;

    // framing state
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_pending, n_pending;
    logic [3:0] r_raw_pos, n_raw_pos;

    // stage 1: decoded result, store read in flight
    logic       r_s1_valid;
    logic       r_s1_kind;
    logic [7:0] r_s1_idx;
    logic [7:0] r_s1_val;
    logic       r_s1_from_mem;

    // output register
    logic       r_out_valid;
    logic       r_out_kind;
    logic [7:0] r_out_idx;
    logic [7:0] r_out_val;

    t_store_req st_req;
    logic [7:0] st_rd_data;

    logic        in_acc;
    logic        out_adv;
    logic        s1_free;
    logic        s0_res;
    logic        s0_kind;
    logic [7:0]  s0_idx;
    logic [7:0]  s0_val;
    logic        s0_from_mem;
    logic [63:0] name_full;
    logic [15:0] name_crc;
    logic [7:0]  synth_val;
    logic [7:0]  name_sel;
    logic [4:0]  cnt_eff;
    logic [4:0]  pos_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol_mode <= 2'd3;
            r_fan_count     <= 5'd16;
            r_gpio_count    <= 5'd16;
            r_device_name   <= '0;
            r_ro_offset     <= 8'd0;
            r_ro_policy     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROTOCOL_MODE: r_protocol_mode <= i_cfg_data[1:0];
                CFG_FAN_COUNT:     r_fan_count     <= i_cfg_data[4:0];
                CFG_GPIO_COUNT:    r_gpio_count    <= i_cfg_data[4:0];
                CFG_DEVICE_NAME:   r_device_name   <= i_cfg_data[NAME_W-1:0];
                CFG_RO_OFFSET:     r_ro_offset     <= i_cfg_data[7:0];
                CFG_RO_POLICY:     r_ro_policy     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: stage 1 drains into the output register whenever that frees up
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_adv;
    assign o_in_stall = !s1_free;
    assign in_acc     = i_in_valid && s1_free;

    // name bytes above NAME_BYTES are zero through the extension
    assign name_full = 64'(r_device_name);

    always_comb begin
        name_crc = CRC_INIT;
        for (int i = 0; i < NAME_BYTES; i++) begin
            name_crc = crc_step(name_crc, name_full[i*8 +: 8]);
        end
    end

    always_comb begin
        name_sel  = i_rx_byte - REG_NAME_FIRST;
        synth_val = 8'd0;
        unique case (i_rx_byte)
            REG_CRC_HI:     synth_val = name_crc[15:8];
            REG_CRC_LO:     synth_val = name_crc[7:0];
            REG_GPIO_COUNT: synth_val = 8'(r_gpio_count);
            REG_FAN_COUNT:  synth_val = 8'(r_fan_count);
            REG_RO_OFFSET:  synth_val = r_ro_offset;
            REG_RO_POLICY:  synth_val = 8'(r_ro_policy);
            REG_ZERO:       synth_val = 8'd0;
            default:        synth_val = name_full[name_sel[2:0]*8 +: 8];
        endcase
    end

    // raw wrap point, clamped to 1..16
    always_comb begin
        if (r_fan_count == 5'd0) begin
            cnt_eff = 5'd1;
        end else if (r_fan_count > 5'd16) begin
            cnt_eff = 5'd16;
        end else begin
            cnt_eff = r_fan_count;
        end
        pos_inc = {1'b0, r_raw_pos} + 5'd1;
    end

    // stage 0: decode the byte, issue the store access
    always_comb begin
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_raw_pos   = r_raw_pos;
        s0_res      = 1'b0;
        s0_kind     = KIND_WRITE;
        s0_idx      = i_rx_byte;
        s0_val      = i_rx_byte;
        s0_from_mem = 1'b0;
        st_req      = '0;
        st_req.wdata = i_rx_byte;
        st_req.raddr = i_rx_byte;
        if (r_protocol_mode == MODE_RAW) begin
            // framing state is left alone in raw mode
            s0_res       = 1'b1;
            s0_idx       = {4'd0, r_raw_pos};
            st_req.we    = in_acc;
            st_req.waddr = {4'd0, r_raw_pos};
            n_raw_pos    = (pos_inc >= cnt_eff) ? 4'd0 : pos_inc[3:0];
        end else begin
            unique case (r_phase)
                PH_VALUE: begin
                    n_phase = PH_IDLE;
                    s0_idx  = r_pending;
                    // writes into the synthesized block are swallowed
                    if (r_pending < FIRST_SYNTH) begin
                        s0_res       = 1'b1;
                        st_req.we    = in_acc;
                        st_req.waddr = r_pending;
                    end
                end
                PH_READ: begin
                    n_phase = PH_IDLE;
                    s0_res  = 1'b1;
                    s0_kind = KIND_READ;
                    s0_val  = synth_val;
                    if (i_rx_byte < FIRST_SYNTH) begin
                        s0_from_mem = 1'b1;
                        st_req.re   = in_acc;
                    end
                end
                default: begin
                    // idle, and the unused code behaves as idle
                    if (i_rx_byte == MARKER) begin
                        n_phase = PH_READ;
                    end else begin
                        n_phase   = PH_VALUE;
                        n_pending = i_rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= 8'd0;
            r_raw_pos <= 4'd0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_raw_pos <= n_raw_pos;
        end
    end

    brcd_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (st_req),
        .o_rd_data (st_rd_data)
    );

    // stage 1 and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= in_acc && s0_res;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && in_acc) begin
            r_s1_kind     <= s0_kind;
            r_s1_idx      <= s0_idx;
            r_s1_val      <= s0_val;
            r_s1_from_mem <= s0_from_mem;
        end
        if (out_adv && r_s1_valid) begin
            r_out_kind <= r_s1_kind;
            r_out_idx  <= r_s1_idx;
            r_out_val  <= r_s1_from_mem ? st_rd_data : r_s1_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_reg_index = r_out_idx;
    assign o_reg_value = r_out_val;

`ifndef SYNTHESIS
    // a store read always lands in a stage 1 word that takes the memory data
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_req.re |=> (r_s1_valid && r_s1_from_mem))
        else $error("store read without matching stage 1 word");

    // every raw byte gives a word
    a_raw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_protocol_mode == MODE_RAW) |=> r_s1_valid)
        else $error("raw byte lost");

    // a blocked stage 1 word keeps its index and its store read data
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_adv) |=> (r_s1_valid && $stable(r_s1_idx) && $stable(st_rd_data)))
        else $error("stage 1 changed while blocked");

    // the synthesized block never reaches the store
    a_no_synth_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_req.we |-> (st_req.waddr < FIRST_SYNTH))
        else $error("write into synthesized register range");
`endif

endmodule

// ===== test/tb_byte_register_command_decoder_unit.sv =====
`timescale 1ns / 1ps

// Checks the byte command decoder against a behavioral mirror of its register map.
// Both channels use valid/stall handshakes. Inputs are driven with NBAs at the rising edge.
// Both sides are sampled at the same edge, so only pre-edge values are seen.
module tb_byte_register_command_decoder_unit;
    import brcd_pkg::*;

    localparam int NAME_LEN = 8;

    typedef enum logic [1:0] {
        FRAME_IDLE  = 2'd0,
        FRAME_VALUE = 2'd1,
        FRAME_READ  = 2'd2
    } t_frame;

    typedef struct packed {
        logic       kind;
        logic [7:0] idx;
        logic [7:0] val;
    } t_reg_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [2:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_rx_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_kind;
    logic [7:0]            o_reg_index;
    logic [7:0]            o_reg_value;

    byte_register_command_decoder_unit #(
        .NAME_BYTES(NAME_LEN)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_reg_index (o_reg_index),
        .o_reg_value (o_reg_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the configuration and decoder state
    logic [1:0]  cfg_mode = 2'd3;
    logic [4:0]  cfg_fans = 5'd16;
    logic [4:0]  cfg_gpio = 5'd16;
    logic [63:0] cfg_name = '0;
    logic [7:0]  cfg_ro_offset = '0;
    logic        cfg_ro_policy = 1'b0;
    t_frame      frame = FRAME_IDLE;
    logic [7:0]  held_index = '0;
    logic [3:0]  raw_pos = '0;
    logic [7:0]  reg_mirror [256];

    t_reg_event  expected_words [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_in_stalls = 0;

    // CRC-16, poly 0x1021, bitwise, over the name bytes
    function automatic logic [15:0] name_checksum();
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < NAME_LEN; i++) begin
            crc = crc ^ {cfg_name[8*i +: 8], 8'h00};
            for (int j = 0; j < 8; j++)
                crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
        end
        return crc;
    endfunction

    function automatic logic [7:0] read_value(input logic [7:0] idx);
        logic [15:0] crc;
        int n;
        crc = name_checksum();
        n = int'(idx) - int'(REG_NAME_FIRST);
        if (idx < FIRST_SYNTH)
            return reg_mirror[idx];
        case (idx)
            REG_CRC_HI:     return crc[15:8];
            REG_CRC_LO:     return crc[7:0];
            REG_GPIO_COUNT: return {3'b000, cfg_gpio};
            REG_FAN_COUNT:  return {3'b000, cfg_fans};
            REG_RO_OFFSET:  return cfg_ro_offset;
            REG_RO_POLICY:  return {7'b0, cfg_ro_policy};
            REG_ZERO:       return 8'h00;
            default:        return (n < NAME_LEN) ? cfg_name[8*n +: 8] : 8'h00;
        endcase
    endfunction

    // advance the mirror by one accepted byte, queue the word it should produce
    task automatic decode_byte(input logic [7:0] b);
        int wrap;
        int pos;
        if (cfg_mode == MODE_RAW) begin
            // wrap point clamps to 1..16; position is written before it wraps
            wrap = (cfg_fans == 0) ? 1 : ((cfg_fans > 16) ? 16 : int'(cfg_fans));
            pos = int'(raw_pos);
            reg_mirror[pos] = b;
            expected_words.push_back('{KIND_WRITE, 8'(pos), b});
            raw_pos = (pos + 1 >= wrap) ? 4'd0 : 4'(pos + 1);
        end else if (frame == FRAME_VALUE) begin
            frame = FRAME_IDLE;
            // synthesized registers swallow the value silently
            if (held_index < FIRST_SYNTH) begin
                reg_mirror[held_index] = b;
                expected_words.push_back('{KIND_WRITE, held_index, b});
            end
        end else if (frame == FRAME_READ) begin
            frame = FRAME_IDLE;
            expected_words.push_back('{KIND_READ, b, read_value(b)});
        end else if (b == MARKER) begin
            frame = FRAME_READ;
        end else begin
            held_index = b;
            frame = FRAME_VALUE;
        end
    endtask

    task automatic check_word();
        t_reg_event want;
        if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d index %0d value %0d",
                   o_kind, o_reg_index, o_reg_value);
            errors++;
        end else begin
            want = expected_words.pop_front();
            if (o_kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, o_kind);
                errors++;
            end
            if (o_reg_index !== want.idx) begin
                $error("reg_index: expected %0d, got %0d", want.idx, o_reg_index);
                errors++;
            end
            if (o_reg_value !== want.val) begin
                $error("reg_value: expected 0x%02h, got 0x%02h", want.val, o_reg_value);
                errors++;
            end
            if (want.kind == KIND_WRITE)
                n_writes++;
            else
                n_reads++;
        end
    endtask

    // monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                decode_byte(i_rx_byte);
            if (i_in_valid && o_in_stall)
                n_in_stalls++;
            if (o_out_valid && !i_out_stall)
                check_word();
        end
    end

    // receiver: random stall, or a long hold-off counted down here
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (expected_words.size() != 0);
        // framing-only bytes give no word; let the pipe settle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PROTOCOL_MODE: cfg_mode = data[1:0];
            CFG_FAN_COUNT:     cfg_fans = data[4:0];
            CFG_GPIO_COUNT:    cfg_gpio = data[4:0];
            CFG_DEVICE_NAME:   cfg_name = data;
            CFG_RO_OFFSET:     cfg_ro_offset = data[7:0];
            CFG_RO_POLICY:     cfg_ro_policy = data[0];
            default: ;
        endcase
    endtask

    function automatic int extreme_or_any(input int lo, input int hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // mostly a small hot set, so reads find earlier writes
    function automatic logic [7:0] pick_register();
        case ($urandom_range(3))
            0, 1:    return 8'($urandom_range(15));
            2:       return 8'($urandom_range(255, 236));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_store_access();
        send_byte(8'd240);
        send_byte(8'hFF);
        send_byte(MARKER);
        send_byte(8'd240);
        send_byte(MARKER);
        send_byte(8'd0);
    endtask

    task automatic test_synth_registers();
        write_cfg(CFG_DEVICE_NAME, 64'h0123_4567_89AB_CDEF);
        write_cfg(CFG_GPIO_COUNT, 64'd0);
        write_cfg(CFG_FAN_COUNT, 64'd17);
        write_cfg(CFG_RO_OFFSET, 64'hFF);
        write_cfg(CFG_RO_POLICY, 64'd1);
        send_byte(MARKER);
        send_byte(REG_CRC_HI);
        send_byte(MARKER);
        send_byte(REG_CRC_LO);
        send_byte(MARKER);
        send_byte(REG_FAN_COUNT);
    endtask

    // a write aimed at a name byte is eaten; the read still shows the name
    task automatic test_dropped_write();
        send_byte(REG_NAME_FIRST);
        send_byte(8'h12);
        send_byte(MARKER);
        send_byte(REG_NAME_FIRST);
    endtask

    task automatic test_raw_wrap();
        write_cfg(CFG_PROTOCOL_MODE, 64'(MODE_RAW));
        write_cfg(CFG_FAN_COUNT, 64'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
        // zero fans wraps at one; position 1 is beyond it but still written
        write_cfg(CFG_FAN_COUNT, 64'd0);
        send_byte(8'h81);
        send_byte(8'h7E);
    endtask

    // index byte held across a trip through raw mode, finished in mode zero
    task automatic test_mode_switch();
        write_cfg(CFG_PROTOCOL_MODE, 64'd3);
        send_byte(8'd7);
        write_cfg(CFG_PROTOCOL_MODE, 64'(MODE_RAW));
        send_byte(8'hC3);
        write_cfg(CFG_PROTOCOL_MODE, 64'd0);
        send_byte(8'h3C);
    endtask

    // receiver holds off while bytes keep coming, so the block fills and stalls
    task automatic test_backpressure();
        write_cfg(CFG_PROTOCOL_MODE, 64'(MODE_RAW));
        write_cfg(CFG_FAN_COUNT, 64'd16);
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 80;
        for (int i = 0; i < 24; i++)
            send_byte(8'($urandom));
    endtask

    task automatic test_random_traffic(input logic [1:0] mode, input int idle,
                                       input int stall, input int n_items);
        int sent;
        int pick;
        logic [63:0] name;
        name = ($urandom_range(2) == 0) ? 64'h0 :
               ($urandom_range(1) ? {64{1'b1}} : {$urandom, $urandom});
        write_cfg(CFG_PROTOCOL_MODE, 64'(mode));
        write_cfg(CFG_FAN_COUNT, 64'(extreme_or_any(0, 31)));
        write_cfg(CFG_GPIO_COUNT, 64'(extreme_or_any(0, 31)));
        write_cfg(CFG_DEVICE_NAME, name);
        write_cfg(CFG_RO_OFFSET, 64'(extreme_or_any(0, 255)));
        write_cfg(CFG_RO_POLICY, 64'($urandom_range(1)));
        wait_drained();
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (cfg_mode == MODE_RAW || pick < 10) begin
                // raw stream, or a stray byte that breaks paired framing
                send_byte(8'($urandom));
                sent++;
            end else if (pick < 55) begin
                send_byte(pick_register());
                send_byte(8'($urandom));
                sent += 2;
            end else begin
                send_byte(MARKER);
                send_byte(pick_register());
                sent += 2;
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        int k;
        foreach (reg_mirror[i])
            reg_mirror[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_store_access();
        test_synth_registers();
        test_dropped_write();
        test_raw_wrap();
        test_mode_switch();
        test_backpressure();
        test_random_traffic(2'd3, 0, 0, 80);
        test_random_traffic(MODE_RAW, 57, 0, 70);
        test_random_traffic(2'd1, 0, 57, 80);
        test_random_traffic(2'd0, 16, 16, 80);
        test_random_traffic(2'd3, 57, 57, 80);

        i_in_valid <= 1'b0;
        for (k = 0; k < 2000 && expected_words.size() != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            errors++;
        end

        $display("Checked %0d write words and %0d read replies; input stalled %0d cycles.",
                 n_writes, n_reads, n_in_stalls);
        $display("Paired and raw framing, synthesized registers, dropped writes, back-pressure.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== byte_register_command_decoder_unit.f =====
rtl/core/brcd_pkg.sv
rtl/core/brcd_store.sv
rtl/core/byte_register_command_decoder_unit.sv
test/tb_byte_register_command_decoder_unit.sv
